// ----- src/wsg_pkg.sv -----
// Package: shared types and constants for the waypoint segment geometry block.
`default_nettype none
package wsg_pkg;
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ITER,
    ST_SCALE,
    ST_HEAD,
    ST_OUT
  } wsg_state_t;

  localparam int ATAN_LEN = 24;
  localparam int GUARD_BITS = 8;
  localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
  localparam logic [15:0] FULL_TURN_Q7 = 16'd46080;
  localparam logic [27:0] HALF_TURN_Q16 = 28'd11796480;
  localparam logic [27:0] FULL_TURN_Q16 = 28'd23592960;

  function automatic logic [21:0] atan_deg_q16(input logic [4:0] i);
    logic [21:0] t;
    case (i)
      5'd0: t = 22'd2949120;
      5'd1: t = 22'd1740967;
      5'd2: t = 22'd919879;
      5'd3: t = 22'd466945;
      5'd4: t = 22'd234379;
      5'd5: t = 22'd117304;
      5'd6: t = 22'd58666;
      5'd7: t = 22'd29335;
      5'd8: t = 22'd14668;
      5'd9: t = 22'd7334;
      5'd10: t = 22'd3667;
      5'd11: t = 22'd1833;
      5'd12: t = 22'd917;
      5'd13: t = 22'd458;
      5'd14: t = 22'd229;
      5'd15: t = 22'd115;
      5'd16: t = 22'd57;
      5'd17: t = 22'd29;
      5'd18: t = 22'd14;
      5'd19: t = 22'd7;
      5'd20: t = 22'd4;
      5'd21: t = 22'd2;
      5'd22: t = 22'd1;
      default: t = 22'd0;
    endcase
    return t;
  endfunction
endpackage
`default_nettype wire

// ----- src/waypoint_segment_geometry.sv -----
// Top level: waypoint step, origin offset, CORDIC length and heading.
`default_nettype none
// One waypoint per transaction. A path start (or the first point after
// reset) and a point equal to the previous one go straight from accept to
// result. Any other point runs one iterative CORDIC vectoring pass of
// CORDIC_STEPS shift-add steps (capped at 24), then a bit-serial gain multiply
// over the full CORDIC magnitude word, then a heading step, then the result.
// The CORDIC adder pair is shared by all steps and the multiplier is
// serial. One item is in flight at a time; the result register holds until
// taken.
module waypoint_segment_geometry import wsg_pkg::*; #(
  parameter int COORD_WIDTH  = 24,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic signed [COORD_WIDTH-1:0] in_point_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_point_y,
  input  wire logic                       in_path_start,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed [COORD_WIDTH:0]     out_step_x,
  output logic signed [COORD_WIDTH:0]     out_step_y,
  output logic signed [COORD_WIDTH:0]     out_rel_x,
  output logic signed [COORD_WIDTH:0]     out_rel_y,
  output logic [COORD_WIDTH:0]            out_segment_length,
  output logic [15:0]                     out_heading_deg,
  output logic                            out_segment_valid
);
  localparam int DW = COORD_WIDTH + 1;
  // CORDIC words: step << 8, growth by gain < 2, plus sign.
  localparam int AW = DW + GUARD_BITS + 2;
  localparam int NSTEP = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
  localparam logic [AW+29:0] LMAX = {{(AW+30-DW){1'b0}}, {DW{1'b1}}};
  // Half an LSB of the length after dropping guard bits and the Q30 gain.
  localparam logic [AW+29:0] LEN_RND = {{(AW-8){1'b0}}, 1'b1, 37'd0};

  wsg_state_t state_r, state_nxt;

  logic signed [COORD_WIDTH-1:0] prev_x_r, prev_y_r, org_x_r, org_y_r;
  logic                          have_prev_r;
  logic signed [AW-1:0]          a_r, b_r;
  logic signed [28:0]            z_r;
  logic                          base_r;
  logic [4:0]                    i_r;
  logic                          mul_start;
  logic                          mul_done;
  logic [AW+29:0]                prod;

  logic signed [DW-1:0] dx, dy, rx, ry;
  logic                 start_pt;

  // Magnitude after the last micro-rotation feeds the multiplier directly.
  logic signed [AW-1:0] a_nx, b_nx, a_sh, b_sh;
  logic [AW-1:0] mag_last;

  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign start_pt = in_path_start || !have_prev_r;
  assign dx = DW'(in_point_x) - DW'(prev_x_r);
  assign dy = DW'(in_point_y) - DW'(prev_y_r);
  assign rx = start_pt ? '0 : DW'(in_point_x) - DW'(org_x_r);
  assign ry = start_pt ? '0 : DW'(in_point_y) - DW'(org_y_r);
  assign mul_start = (state_r == ST_ITER) && (i_r == 5'(NSTEP - 1));

  wsg_gain #(.AW(AW)) u_gain (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .mag(mag_last),
    .done(mul_done), .prod(prod)
  );

  assign a_sh = a_r >>> i_r;
  assign b_sh = b_r >>> i_r;
  assign a_nx = b_r[AW-1] ? a_r - b_sh : a_r + b_sh;
  assign b_nx = b_r[AW-1] ? b_r + a_sh : b_r - a_sh;
  assign mag_last = a_nx[AW-1] ? '0 : a_nx;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) begin
        if (start_pt || (dx == '0 && dy == '0)) state_nxt = ST_OUT;
        else state_nxt = ST_ITER;
      end
      ST_ITER:  if (i_r == 5'(NSTEP - 1)) state_nxt = ST_SCALE;
      ST_SCALE: if (mul_done) state_nxt = ST_HEAD;
      ST_HEAD:  state_nxt = ST_OUT;
      ST_OUT:   if (out_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  logic signed [28:0] h;
  logic signed [28:0] hw;
  logic signed [19:0] r;
  logic [AW+29:0]     p;
  assign h  = (base_r ? 29'sd11796480 : 29'sd0) + z_r;
  assign hw = h[28] ? h + 29'sd23592960 : h;
  assign r  = 20'((hw + 29'sd256) >>> 9);
  // Drop 8 guard bits and 30 gain fraction bits, round half up.
  assign p  = (prod + LEN_RND) >> 38;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
      prev_x_r <= '0; prev_y_r <= '0; org_x_r <= '0; org_y_r <= '0;
    end else if (in_valid && in_ready) begin
      // Latch point and record step / offset for the result.
      have_prev_r <= 1'b1;
      prev_x_r <= in_point_x;
      prev_y_r <= in_point_y;
      if (start_pt) begin
        org_x_r <= in_point_x;
        org_y_r <= in_point_y;
      end
      out_step_x <= start_pt ? '0 : dx;
      out_step_y <= start_pt ? '0 : dy;
      out_rel_x <= rx;
      out_rel_y <= ry;
      out_segment_valid <= !start_pt;
      out_segment_length <= '0;
      out_heading_deg <= '0;
      i_r <= '0;
      z_r <= '0;
      base_r <= dx[DW-1];
      a_r <= dx[DW-1] ? -(AW'(dx) <<< GUARD_BITS) : (AW'(dx) <<< GUARD_BITS);
      b_r <= dx[DW-1] ? -(AW'(dy) <<< GUARD_BITS) : (AW'(dy) <<< GUARD_BITS);
    end else if (state_r == ST_ITER) begin
      // Advance one micro-rotation.
      a_r <= a_nx;
      b_r <= b_nx;
      z_r <= b_r[AW-1] ? z_r - 29'(atan_deg_q16(i_r)) : z_r + 29'(atan_deg_q16(i_r));
      i_r <= i_r + 5'd1;
    end else if (state_r == ST_SCALE && mul_done) begin
      out_segment_length <= (p > LMAX) ? DW'(LMAX) : DW'(p);
    end else if (state_r == ST_HEAD) begin
      if (r < 0) out_heading_deg <= 16'(r + 20'sd46080);
      else if (r >= 20'sd46080) out_heading_deg <= 16'(r - 20'sd46080);
      else out_heading_deg <= 16'(r);
    end
  end

`ifndef ASSERT_OFF
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_heading_deg))
    else $error("result dropped");
  a_head_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_heading_deg < FULL_TURN_Q7) else $error("heading range");
  a_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_segment_valid |-> out_segment_length == '0)
    else $error("length on path start");
`endif
endmodule
`default_nettype wire

// ----- src/wsg_gain.sv -----
// Bit-serial multiplier: scales the CORDIC magnitude by the inverse gain.
`default_nettype none
module wsg_gain import wsg_pkg::*; #(
  parameter int AW = 35
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [AW-1:0] mag,
  output logic               done,
  output logic [AW+29:0]     prod
);
  localparam int CW = $clog2(AW + 1);
  logic [AW-1:0]   sh_r;
  logic [AW+29:0]  acc_r;
  logic [AW+29:0]  mc_r;
  logic [CW-1:0]   cnt_r;
  logic            busy_r;

  // Shift-add, one multiplier bit per cycle, LSB first.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      sh_r   <= mag;
      acc_r  <= '0;
      mc_r   <= {{AW{1'b0}}, INV_GAIN_Q30};
    end else if (busy_r) begin
      if (sh_r[0]) acc_r <= acc_r + mc_r;
      sh_r  <= sh_r >> 1;
      mc_r  <= mc_r << 1;
      cnt_r <= cnt_r + CW'(1);
      if (cnt_r == CW'(AW - 1)) busy_r <= 1'b0;
    end
  end

  assign done = busy_r && (cnt_r == CW'(AW - 1));
  assign prod = (sh_r[0] && busy_r) ? acc_r + mc_r : acc_r;
endmodule
`default_nettype wire

// ----- verif/tb.sv -----
// Testbench for the waypoint segment geometry block: directed table plus random paths.
`default_nettype none
module tb;
  import wsg_pkg::*;

  localparam int CW = 24;
  localparam int STEPS = 16;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_RANDOM = 2000;

  // Result of one transaction on the output channel.
  typedef struct packed {
    logic signed [CW:0] step_x;
    logic signed [CW:0] step_y;
    logic signed [CW:0] rel_x;
    logic signed [CW:0] rel_y;
    logic [CW:0]        seg_len;
    logic [15:0]        heading;
    logic               seg_valid;
  } seg_result_t;

  // One row of directed stimulus; has_gold marks a hand-computed result.
  typedef struct {
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic                 start;
    bit                   has_gold;
    seg_result_t          gold;
  } waypoint_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CW-1:0] in_point_x = '0;
  logic signed [CW-1:0] in_point_y = '0;
  logic in_path_start = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  seg_result_t dut_res;

  always #5 clk = ~clk;

  waypoint_segment_geometry #(.COORD_WIDTH(CW), .CORDIC_STEPS(STEPS)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_path_start(in_path_start),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_step_x(dut_res.step_x), .out_step_y(dut_res.step_y),
    .out_rel_x(dut_res.rel_x), .out_rel_y(dut_res.rel_y),
    .out_segment_length(dut_res.seg_len), .out_heading_deg(dut_res.heading),
    .out_segment_valid(dut_res.seg_valid)
  );

  // Predictor state: mirrors the block's previous point and path origin.
  longint last_x, last_y, orig_x, orig_y;
  bit     seen_point;

  seg_result_t expected_q[$];
  int  fail_count = 0;
  int  idle_cycles = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  stim_done = 1'b0;

  // Run the vectoring CORDIC over the step, giving length and wrapped heading.
  task automatic cordic_length_heading(input longint dx, input longint dy,
                                       output logic [CW:0] len,
                                       output logic [15:0] head);
    longint a, b, a0, z, base, h, r;
    longint unsigned ua, p, lmax;
    logic [21:0] ang [0:23];
    ang = '{22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379,
            22'd117304, 22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667,
            22'd1833, 22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29,
            22'd14, 22'd7, 22'd4, 22'd2, 22'd1, 22'd0};
    z = 0;
    base = 0;
    if (dx < 0) begin
      a = -dx * 256;
      b = -dy * 256;
      base = 180 * 65536;
    end else begin
      a = dx * 256;
      b = dy * 256;
    end
    for (int i = 0; i < ((STEPS > 24) ? 24 : STEPS); i++) begin
      a0 = a;
      // >>> on a signed longint is a floor shift
      if (b >= 0) begin
        a = a + (b >>> i);
        b = b - (a0 >>> i);
        z = z + longint'(ang[i]);
      end else begin
        a = a - (b >>> i);
        b = b + (a0 >>> i);
        z = z - longint'(ang[i]);
      end
    end
    ua = (a < 0) ? 0 : longint'(a);
    p = (ua >> 8) * 64'd652032874 + (((ua & 64'd255) * 64'd652032874) >> 8);
    p = (p + (64'd1 << 29)) >> 30;
    lmax = (64'd1 << (CW + 1)) - 1;
    len = (p > lmax) ? lmax[CW:0] : p[CW:0];
    h = base + z;
    if (h < 0) h = h + 360 * 65536;
    r = (h + 256) >>> 9;
    while (r < 0) r = r + 46080;
    while (r >= 46080) r = r - 46080;
    head = r[15:0];
  endtask

  // Advance the predictor by one waypoint and return the expected result.
  task automatic predict_segment(input logic signed [CW-1:0] px,
                                 input logic signed [CW-1:0] py,
                                 input logic start_flag,
                                 output seg_result_t res);
    longint x, y, dx, dy, ox, oy;
    bit     begins;
    x = px;
    y = py;
    dx = 0;
    dy = 0;
    begins = start_flag || !seen_point;
    res = '0;
    if (begins) begin
      orig_x = x;
      orig_y = y;
    end else begin
      dx = x - last_x;
      dy = y - last_y;
      if (dx != 0 || dy != 0) cordic_length_heading(dx, dy, res.seg_len, res.heading);
    end
    ox = x - orig_x;
    oy = y - orig_y;
    res.step_x = dx[CW:0];
    res.step_y = dy[CW:0];
    res.rel_x = ox[CW:0];
    res.rel_y = oy[CW:0];
    res.seg_valid = !begins;
    last_x = x;
    last_y = y;
    seen_point = 1'b1;
  endtask

  // Hold one waypoint on the input channel until it is accepted.
  task automatic send_waypoint(input logic signed [CW-1:0] px,
                               input logic signed [CW-1:0] py,
                               input logic start_flag,
                               input bit has_gold, input seg_result_t gold);
    seg_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    predict_segment(px, py, start_flag, res);
    if (has_gold && res !== gold) begin
      $display("%0t predictor disagrees with table row: table %p, predictor %p",
               $time, gold, res);
      fail_count++;
    end
    in_valid <= 1'b1;
    in_point_x <= px;
    in_point_y <= py;
    in_path_start <= start_flag;
    expected_q.push_back(has_gold ? gold : res);
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  // Drive the receiver stall and check each result against the oldest expectation.
  always @(posedge clk) begin
    seg_result_t exp_res;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t unexpected result %p", $time, dut_res);
          fail_count++;
        end else begin
          exp_res = expected_q.pop_front();
          if (dut_res.step_x !== exp_res.step_x)
            $display("%0t step_x exp %0d got %0d", $time, exp_res.step_x, dut_res.step_x);
          if (dut_res.step_y !== exp_res.step_y)
            $display("%0t step_y exp %0d got %0d", $time, exp_res.step_y, dut_res.step_y);
          if (dut_res.rel_x !== exp_res.rel_x)
            $display("%0t rel_x exp %0d got %0d", $time, exp_res.rel_x, dut_res.rel_x);
          if (dut_res.rel_y !== exp_res.rel_y)
            $display("%0t rel_y exp %0d got %0d", $time, exp_res.rel_y, dut_res.rel_y);
          if (dut_res.seg_len !== exp_res.seg_len)
            $display("%0t segment_length exp %0d got %0d", $time, exp_res.seg_len,
                     dut_res.seg_len);
          if (dut_res.heading !== exp_res.heading)
            $display("%0t heading_deg exp %0d got %0d", $time, exp_res.heading,
                     dut_res.heading);
          if (dut_res.seg_valid !== exp_res.seg_valid)
            $display("%0t segment_valid exp %0b got %0b", $time, exp_res.seg_valid,
                     dut_res.seg_valid);
          if (dut_res !== exp_res) fail_count++;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: count cycles with no transaction on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic seg_result_t mk_gold(longint sx, longint sy, longint rx, longint ry,
                                          longint len, longint hd, bit v);
    seg_result_t g;
    g.step_x = sx[CW:0];
    g.step_y = sy[CW:0];
    g.rel_x = rx[CW:0];
    g.rel_y = ry[CW:0];
    g.seg_len = len[CW:0];
    g.heading = hd[15:0];
    g.seg_valid = v;
    return g;
  endfunction

  waypoint_row_t directed[$];
  logic signed [CW-1:0] rx, ry;
  int phase_pick;

  initial begin
    // First point after reset without flag is still treated as a path start.
    directed.push_back('{24'sd1000, -24'sd500, 1'b0, 1'b1,
                         mk_gold(0, 0, 0, 0, 0, 0, 1'b0)});
    // Zero step: length and heading zero, but segment valid.
    directed.push_back('{24'sd1000, -24'sd500, 1'b0, 1'b1,
                         mk_gold(0, 0, 0, 0, 0, 0, 1'b1)});
    directed.push_back('{24'sd1256, -24'sd500, 1'b0, 1'b0, '0});
    directed.push_back('{24'sd1256, -24'sd244, 1'b0, 1'b0, '0});
    directed.push_back('{24'sd0, -24'sd244, 1'b0, 1'b0, '0});
    directed.push_back('{24'sd0, -24'sd2000, 1'b0, 1'b0, '0});
    directed.push_back('{24'sd300, -24'sd2300, 1'b0, 1'b0, '0});
    directed.push_back('{-24'sd300, 24'sd2300, 1'b0, 1'b0, '0});
    // New path at the corners of the coordinate range.
    directed.push_back('{24'h7FFFFF, 24'h7FFFFF, 1'b1, 1'b1,
                         mk_gold(0, 0, 0, 0, 0, 0, 1'b0)});
    directed.push_back('{24'h800000, 24'h800000, 1'b0, 1'b0, '0});
    directed.push_back('{24'h7FFFFF, 24'h800000, 1'b0, 1'b0, '0});
    directed.push_back('{24'h800000, 24'h7FFFFF, 1'b0, 1'b0, '0});
    directed.push_back('{24'h800000, 24'h800000, 1'b0, 1'b0, '0});
    directed.push_back('{24'h7FFFFF, 24'h7FFFFF, 1'b0, 1'b0, '0});
    directed.push_back('{24'sd0, 24'sd0, 1'b1, 1'b1, mk_gold(0, 0, 0, 0, 0, 0, 1'b0)});
    directed.push_back('{-24'sd1, 24'sd0, 1'b0, 1'b0, '0});
    directed.push_back('{-24'sd1, -24'sd1, 1'b0, 1'b0, '0});
    directed.push_back('{24'sd0, -24'sd1, 1'b0, 1'b0, '0});
    directed.push_back('{24'sd5, 24'sd3, 1'b1, 1'b1, mk_gold(0, 0, 0, 0, 0, 0, 1'b0)});

    seen_point = 1'b0;
    last_x = 0;
    last_y = 0;
    orig_x = 0;
    orig_y = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i])
      send_waypoint(directed[i].px, directed[i].py, directed[i].start,
                    directed[i].has_gold, directed[i].gold);

    // Random paths: mostly short local steps, some full-range jumps and new paths.
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 400 == 0) begin
        phase_pick = (n / 400) % 4;
        send_idle_pct = (phase_pick == 1 || phase_pick == 3) ? ((phase_pick == 3) ? 23 : 46) : 0;
        recv_stall_pct = (phase_pick == 2 || phase_pick == 3) ? ((phase_pick == 3) ? 23 : 46) : 0;
      end
      case ($urandom_range(9))
        0, 1: begin
          rx = CW'($urandom);
          ry = CW'($urandom);
        end
        default: begin
          rx = CW'(last_x + $signed($urandom_range(8000)) - 4000);
          ry = CW'(last_y + $signed($urandom_range(8000)) - 4000);
        end
      endcase
      send_waypoint(rx, ry, ($urandom_range(19) == 0), 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
`default_nettype wire

// ----- waypoint_segment_geometry.f -----
src/wsg_pkg.sv
src/wsg_gain.sv
src/waypoint_segment_geometry.sv
verif/tb.sv
